// File: rtl/rnta_pkg.sv
// shared types, constants and the digit character function of the radix converter
`timescale 1ns / 1ps
package rnta_pkg;

    // width of the converted value, 8 to 64
    localparam int VALUE_WIDTH = 64;

    // dividend bits consumed by the divider in one cycle
    localparam int DIV_STEPS  = 8;
    localparam int NUM_CHUNKS = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUOT_W     = NUM_CHUNKS * DIV_STEPS;
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int IDX_W      = $clog2(VALUE_WIDTH);

    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    localparam int FLAG_UNSIGNED = 0;
    localparam int FLAG_LOWER    = 1;

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_UPPER_A = 7'h41;
    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [3:0] DIGIT_TEN    = 4'd10;

    typedef struct packed {
        logic signed [63:0] value;
        logic [4:0]         base;
        logic [1:0]         format_flags;
    } t_in_req;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       negative;
        logic       last;
    } t_out_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SEND
    } t_state;

    function automatic logic [6:0] digit_to_char(input logic [3:0] d, input logic lower);
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + 7'(d);
        end else begin
            return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 7'(d - DIGIT_TEN);
        end
    endfunction

endpackage

// File: rtl/radix_number_to_ascii.sv
// top level of the radix converter: sequencer, quotient register, digit store, output
// Converts one value per request into ASCII digits of base 2..16, most significant first,
// with the sign reported as a flag on every digit. Each digit is divided out by the shared
// divider, which takes 8 dividend bits per cycle, and written to the digit store; once the
// quotient is zero the digits are read back (ST_READ) and presented (ST_SEND) one by one,
// each held in ST_SEND until the sink is ready. A full binary value gives up to 64 digits.
// o_ready is high only between items.
`timescale 1ns / 1ps
module radix_number_to_ascii (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rnta_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rnta_pkg::t_out_req o_data
);
    import rnta_pkg::*;

    t_state              r_state, n_state;
    logic [QUOT_W-1:0]   r_quot, n_quot;
    logic [3:0]          r_rem, n_rem;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [4:0]          r_base, n_base;
    logic                r_sign, n_sign;
    logic                r_case, n_case;
    logic [3:0]          r_rd;

    logic [3:0]          mem [VALUE_WIDTH];
    logic                mem_we;

    logic [VALUE_WIDTH-1:0] in_v;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   in_neg;
    logic [4:0]             in_base;

    logic [3:0]           step_rem;
    logic [DIV_STEPS-1:0] step_quot;

    assign in_v   = i_data.value[VALUE_WIDTH-1:0];
    assign in_neg = !i_data.format_flags[FLAG_UNSIGNED] && in_v[VALUE_WIDTH-1];
    // most negative value negates to itself, which reads correctly as unsigned
    assign in_mag = in_neg ? (~in_v) + VALUE_WIDTH'(1) : in_v;
    assign in_base = (i_data.base < BASE_MIN) ? BASE_MIN :
                     (i_data.base > BASE_MAX) ? BASE_MAX : i_data.base;

    rnta_div_step u_div (
        .i_rem  (r_rem),
        .i_bits (r_quot[QUOT_W-1 -: DIV_STEPS]),
        .i_base (r_base),
        .o_rem  (step_rem),
        .o_quot (step_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chunk <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_chunk <= n_chunk;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_idx  <= n_idx;
        r_base <= n_base;
        r_sign <= n_sign;
        r_case <= n_case;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt] <= step_rem;
        end
        if (r_state == ST_READ) begin
            r_rd <= mem[r_idx];
        end
    end

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_base  = r_base;
        n_sign  = r_sign;
        n_case  = r_case;
        mem_we  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_quot  = QUOT_W'(in_mag);
                    n_rem   = '0;
                    n_chunk = '0;
                    n_cnt   = '0;
                    n_base  = in_base;
                    n_sign  = in_neg;
                    n_case  = i_data.format_flags[FLAG_LOWER];
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // quotient bits shift in at the bottom as dividend bits leave the top
                n_rem   = step_rem;
                n_quot  = QUOT_W'(r_quot << DIV_STEPS) | QUOT_W'(step_quot);
                n_chunk = CHUNK_W'(r_chunk + 1'b1);
                if (r_chunk == CHUNK_W'(NUM_CHUNKS - 1)) begin
                    mem_we  = 1'b1;
                    n_cnt   = IDX_W'(r_cnt + 1'b1);
                    n_chunk = '0;
                    n_rem   = '0;
                    if (n_quot == '0) begin
                        n_idx   = r_cnt;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_SEND;
            end
            ST_SEND: begin
                if (i_ready) begin
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = IDX_W'(r_idx - 1'b1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready           = (r_state == ST_IDLE);
    assign o_valid           = (r_state == ST_SEND);
    assign o_data.digit_char = digit_to_char(r_rd, r_case);
    assign o_data.negative   = r_sign;
    assign o_data.last       = (r_idx == '0);

`ifndef SYNTH
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < r_base))
        else $error("divider remainder not below base");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last digit");

    a_more_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last) |=> (r_state == ST_READ))
        else $error("digit run cut short");

    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_SEND && $stable(r_idx)))
        else $error("store read not followed by output");
`endif

endmodule

// File: rtl/rnta_div_step.sv
// restoring divider slice: DIV_STEPS dividend bits against a small base per cycle
`timescale 1ns / 1ps
module rnta_div_step (
    input  logic [3:0]                   i_rem,
    input  logic [rnta_pkg::DIV_STEPS-1:0] i_bits,
    input  logic [4:0]                   i_base,
    output logic [3:0]                   o_rem,
    output logic [rnta_pkg::DIV_STEPS-1:0] o_quot
);
    import rnta_pkg::*;

    always_comb begin
        logic [3:0] rem;
        logic [4:0] trial;
        rem    = i_rem;
        trial  = '0;
        o_quot = '0;
        // remainder stays below the base, so it always fits in four bits
        for (int i = DIV_STEPS - 1; i >= 0; i--) begin
            trial = {rem, i_bits[i]};
            if (trial >= i_base) begin
                rem       = 4'(trial - i_base);
                o_quot[i] = 1'b1;
            end else begin
                rem = trial[3:0];
            end
        end
        o_rem = rem;
    end

endmodule
